// ===== rtl/tts_pkg.sv =====
// Shared types, constants and helpers for the tick task scheduler table.
// Used by the slot cell, the head update unit and the top level.
// No dependencies.
package tts_pkg;

    // Table geometry
    localparam int TASK_SLOTS  = 16;
    localparam int MAX_RESULTS = 16;
    localparam int IDX_W       = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int RUN_W       = $clog2(MAX_RESULTS + 1);
    localparam int SLOT_OUT_W  = 5;

    // Stream payload widths
    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 16;

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [RUN_W-1:0]      run_t;
    typedef logic [SLOT_OUT_W-1:0] slot_out_t;

    // Command codes
    typedef enum logic [1:0] {
        CMD_ADD      = 2'd0,
        CMD_DELETE   = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_DISPATCH = 2'd3
    } cmd_e;

    // "Full" / "none" slot code, masked to the result field
    localparam logic [31:0] SLOT_NONE_FULL = 32'(TASK_SLOTS);
    localparam slot_out_t   SLOT_NONE      = SLOT_NONE_FULL[SLOT_OUT_W-1:0];

    // One task slot
    typedef struct packed {
        logic        valid;
        logic [7:0]  job;
        logic [31:0] delay;
        logic [31:0] period;
        logic [7:0]  pending;
    } slot_t;

    // Per-step events from the head unit to the sequencer
    typedef struct packed {
        logic placed;    // add took this slot
        logic was_used;  // delete hit a slot in use
        logic run;       // dispatch ran this slot
    } head_ctrl_t;

    // Slot index to the 5-bit result field
    function automatic slot_out_t idx_to_slot(input idx_t idx);
        logic [31:0] wide;
        wide = 32'(idx);
        return wide[SLOT_OUT_W-1:0];
    endfunction

endpackage

// ===== rtl/tts_cell.sv =====
// One storage cell of the rotating slot ring.
// Loads its neighbor's slot on every shift. Depends on tts_pkg.
module tts_cell (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           shift_en,
    input  tts_pkg::slot_t d_in,
    output tts_pkg::slot_t q_out
);

    tts_pkg::slot_t slot_reg;
    tts_pkg::slot_t slot_next;

    // hold unless the ring advances
    always_comb begin
        slot_next = slot_reg;
        if (shift_en) begin
            slot_next = d_in;
        end
    end

    // only the valid mark needs a reset
    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        if (!aresetn) begin
            slot_reg.valid <= 1'b0;
        end
    end

    assign q_out = slot_reg;

endmodule

// ===== rtl/tts_head.sv =====
// Update unit at the head of the slot ring: applies the current command to
// the slot passing by and flags add, delete and run events. Depends on tts_pkg.
module tts_head (
    input  tts_pkg::cmd_e       cmd,
    input  logic [7:0]          task_code,
    input  logic [31:0]         first_delay,
    input  logic [31:0]         repeat_period,
    input  logic [7:0]          slot_select,
    input  tts_pkg::idx_t       idx,
    input  logic                found,
    input  logic                runs_full,
    input  tts_pkg::slot_t      slot_in,
    output tts_pkg::slot_t      slot_out,
    output tts_pkg::head_ctrl_t ctrl
);

    logic sel_match;

    assign sel_match = (32'(slot_select) == 32'(idx));

    always_comb begin
        slot_out = slot_in;
        ctrl     = '0;
        unique case (cmd)
            tts_pkg::CMD_ADD: begin
                // first free slot takes the task
                if (!found && !slot_in.valid) begin
                    slot_out.valid   = 1'b1;
                    slot_out.job     = task_code;
                    slot_out.delay   = first_delay;
                    slot_out.period  = repeat_period;
                    slot_out.pending = 8'd0;
                    ctrl.placed      = 1'b1;
                end
            end
            tts_pkg::CMD_DELETE: begin
                if (sel_match) begin
                    slot_out      = '0;
                    ctrl.was_used = slot_in.valid;
                end
            end
            tts_pkg::CMD_TICK: begin
                // count down, or log a run and reload
                if (slot_in.valid) begin
                    if (slot_in.delay == 32'd0) begin
                        if (slot_in.pending != 8'hFF) begin
                            slot_out.pending = slot_in.pending + 8'd1;
                        end
                        if (slot_in.period != 32'd0) begin
                            slot_out.delay = slot_in.period;
                        end
                    end else begin
                        slot_out.delay = slot_in.delay - 32'd1;
                    end
                end
            end
            tts_pkg::CMD_DISPATCH: begin
                // consume one run; one-shot slots are freed
                if (slot_in.valid && slot_in.pending != 8'd0 && !runs_full) begin
                    ctrl.run = 1'b1;
                    if (slot_in.period == 32'd0) begin
                        slot_out = '0;
                    end else begin
                        slot_out.pending = slot_in.pending - 8'd1;
                    end
                end
            end
            default: begin
                slot_out = slot_in;
            end
        endcase
    end

endmodule

// ===== rtl/tick_task_scheduler_table.sv =====
// Top level of the tick task scheduler table: request sequencer, ring of
// slot cells and result register. Depends on tts_pkg, tts_cell, tts_head.
//
// Usage:
//   Requests enter on the s_ channel: s_tuser carries the command (add,
//   delete, tick, dispatch), s_tdata the task code, first delay, period
//   and slot to delete. Results leave on the m_ channel: m_tuser echoes
//   the command, m_tdata holds slot, job code and ok, m_tlast marks the
//   final result of a request.
//   The slots sit in a ring of TASK_SLOTS cells that rotates by one each
//   cycle while a request is worked and no result waits on a stall; the
//   head unit updates the slot that passes it, so every request takes one
//   full turn of the ring. The final result of a request is registered as
//   the sequencer returns to idle; only then is the next request taken, so
//   requests do not overlap. Dispatch results for earlier ready slots
//   appear during the turn, each one held back until the next is known.
//   A stalled receiver (m_tready low with a result waiting) freezes the
//   ring; nothing is lost. Reset marks every slot free and empties the
//   result register; no clearing pass is needed.
module tick_task_scheduler_table (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // [7:0] task_code, [39:8] first_delay, [71:40] repeat_period, [79:72] slot_select
    input  logic [79:0] s_tdata,
    // [1:0] cmd
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // [4:0] slot, [12:5] job_code, [13] ok, [15:14] zero
    output logic [15:0] m_tdata,
    // [1:0] kind
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // latched request
    tts_pkg::cmd_e cmd_reg, cmd_next;
    logic [7:0]    code_reg, code_next;
    logic [31:0]   delay_reg, delay_next;
    logic [31:0]   period_reg, period_next;
    logic [7:0]    sel_reg, sel_next;

    // scan progress
    tts_pkg::idx_t step_reg, step_next;
    logic          found_reg, found_next;
    tts_pkg::idx_t found_idx_reg, found_idx_next;
    logic          was_reg, was_next;
    tts_pkg::run_t runs_reg, runs_next;

    // held dispatch result
    logic          hold_valid_reg, hold_valid_next;
    tts_pkg::idx_t hold_idx_reg, hold_idx_next;
    logic [7:0]    hold_job_reg, hold_job_next;

    // result register
    logic                  out_valid_reg, out_valid_next;
    tts_pkg::cmd_e         out_kind_reg, out_kind_next;
    tts_pkg::slot_out_t    out_slot_reg, out_slot_next;
    logic [7:0]            out_job_reg, out_job_next;
    logic                  out_ok_reg, out_ok_next;
    logic                  out_last_reg, out_last_next;

    logic                out_free;
    logic                shift_en;
    logic                in_fire;
    logic                runs_full;
    logic                sel_in_range;
    tts_pkg::slot_t      cell_q [tts_pkg::TASK_SLOTS];
    tts_pkg::slot_t      head_new;
    tts_pkg::head_ctrl_t head_ctrl;

    assign out_free     = !out_valid_reg || m_tready;
    assign s_tready     = (state_reg == ST_IDLE);
    assign in_fire      = s_tvalid && s_tready;
    assign shift_en     = (state_reg == ST_SCAN) && out_free;
    assign runs_full    = (runs_reg == tts_pkg::run_t'(tts_pkg::MAX_RESULTS));
    assign sel_in_range = (32'(sel_reg) < 32'(tts_pkg::TASK_SLOTS));

    // ring of slot cells; the head's update wraps into the tail
    genvar k;
    generate
        for (k = 0; k < tts_pkg::TASK_SLOTS; k++) begin : g_cell
            tts_pkg::slot_t d_in;
            if (k == tts_pkg::TASK_SLOTS - 1) begin : g_tail
                assign d_in = head_new;
            end else begin : g_mid
                assign d_in = cell_q[k+1];
            end
            tts_cell u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .shift_en (shift_en),
                .d_in     (d_in),
                .q_out    (cell_q[k])
            );
        end
    endgenerate

    tts_head u_head (
        .cmd           (cmd_reg),
        .task_code     (code_reg),
        .first_delay   (delay_reg),
        .repeat_period (period_reg),
        .slot_select   (sel_reg),
        .idx           (step_reg),
        .found         (found_reg),
        .runs_full     (runs_full),
        .slot_in       (cell_q[0]),
        .slot_out      (head_new),
        .ctrl          (head_ctrl)
    );

    // sequencer and result assembly
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        code_next       = code_reg;
        delay_next      = delay_reg;
        period_next     = period_reg;
        sel_next        = sel_reg;
        step_next       = step_reg;
        found_next      = found_reg;
        found_idx_next  = found_idx_reg;
        was_next        = was_reg;
        runs_next       = runs_reg;
        hold_valid_next = hold_valid_reg;
        hold_idx_next   = hold_idx_reg;
        hold_job_next   = hold_job_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_kind_next   = out_kind_reg;
        out_slot_next   = out_slot_reg;
        out_job_next    = out_job_reg;
        out_ok_next     = out_ok_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    cmd_next        = tts_pkg::cmd_e'(s_tuser);
                    code_next       = s_tdata[7:0];
                    delay_next      = s_tdata[39:8];
                    period_next     = s_tdata[71:40];
                    sel_next        = s_tdata[79:72];
                    step_next       = '0;
                    found_next      = 1'b0;
                    was_next        = 1'b0;
                    runs_next       = '0;
                    hold_valid_next = 1'b0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (shift_en) begin
                    if (head_ctrl.placed) begin
                        found_next     = 1'b1;
                        found_idx_next = step_reg;
                    end
                    if (head_ctrl.was_used) begin
                        was_next = 1'b1;
                    end
                    // a new run pushes out the one held before it
                    if (head_ctrl.run) begin
                        runs_next = runs_reg + tts_pkg::run_t'(1);
                        if (hold_valid_reg) begin
                            out_valid_next = 1'b1;
                            out_kind_next  = tts_pkg::CMD_DISPATCH;
                            out_slot_next  = tts_pkg::idx_to_slot(hold_idx_reg);
                            out_job_next   = hold_job_reg;
                            out_ok_next    = 1'b1;
                            out_last_next  = 1'b0;
                        end
                        hold_valid_next = 1'b1;
                        hold_idx_next   = step_reg;
                        hold_job_next   = cell_q[0].job;
                    end
                    if (step_reg == tts_pkg::idx_t'(tts_pkg::TASK_SLOTS - 1)) begin
                        state_next = ST_FINISH;
                    end else begin
                        step_next = step_reg + tts_pkg::idx_t'(1);
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = cmd_reg;
                    out_job_next   = 8'd0;
                    out_last_next  = 1'b1;
                    unique case (cmd_reg)
                        tts_pkg::CMD_ADD: begin
                            out_slot_next = found_reg ? tts_pkg::idx_to_slot(found_idx_reg)
                                                      : tts_pkg::SLOT_NONE;
                            out_ok_next   = found_reg;
                        end
                        tts_pkg::CMD_DELETE: begin
                            out_slot_next = sel_in_range ? sel_reg[tts_pkg::SLOT_OUT_W-1:0]
                                                         : tts_pkg::SLOT_NONE;
                            out_ok_next   = sel_in_range && was_reg;
                        end
                        tts_pkg::CMD_TICK: begin
                            out_slot_next = tts_pkg::SLOT_NONE;
                            out_ok_next   = 1'b1;
                        end
                        tts_pkg::CMD_DISPATCH: begin
                            if (hold_valid_reg) begin
                                out_slot_next = tts_pkg::idx_to_slot(hold_idx_reg);
                                out_job_next  = hold_job_reg;
                                out_ok_next   = 1'b1;
                            end else begin
                                out_slot_next = tts_pkg::SLOT_NONE;
                                out_ok_next   = 1'b0;
                            end
                        end
                        default: begin
                            out_slot_next = tts_pkg::SLOT_NONE;
                            out_ok_next   = 1'b0;
                        end
                    endcase
                    hold_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // registers
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        code_reg       <= code_next;
        delay_reg      <= delay_next;
        period_reg     <= period_next;
        sel_reg        <= sel_next;
        step_reg       <= step_next;
        found_idx_reg  <= found_idx_next;
        was_reg        <= was_next;
        found_reg      <= found_next;
        hold_idx_reg   <= hold_idx_next;
        hold_job_reg   <= hold_job_next;
        out_kind_reg   <= out_kind_next;
        out_slot_reg   <= out_slot_next;
        out_job_reg    <= out_job_next;
        out_ok_reg     <= out_ok_next;
        out_last_reg   <= out_last_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            runs_reg       <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            runs_reg       <= runs_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // output ports
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_ok_reg, out_job_reg, out_slot_reg};

    // checks
    a_step_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> (32'(step_reg) < 32'(tts_pkg::TASK_SLOTS)))
        else $error("scan step past the last slot");

    a_runs_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(runs_reg) <= 32'(tts_pkg::MAX_RESULTS))
        else $error("dispatch run count over the result limit");

    a_hold_dispatch_only: assert property (@(posedge aclk) disable iff (!aresetn)
        (hold_valid_reg && state_reg != ST_IDLE) |-> (cmd_reg == tts_pkg::CMD_DISPATCH))
        else $error("held run outside a dispatch request");

    a_accept_starts_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_SCAN && step_reg == '0))
        else $error("accepted request did not start a scan");

endmodule

// ===== test/tts_sched_scoreboard.sv =====
// Scoreboard for the tick task scheduler table: keeps its own copy of the
// slot table, predicts the results of each accepted request and checks them.
// Depends on tts_pkg.
package tts_sched_sb_pkg;
    import tts_pkg::*;

    // One expected result
    typedef struct packed {
        cmd_e       kind;
        slot_out_t  slot;
        logic [7:0] job;
        logic       ok;
        logic       is_last;
    } sched_result_t;

    class sched_scoreboard;
        slot_t         slot_state[TASK_SLOTS];
        sched_result_t expected_results[$];
        int errors;
        int checked;
        int accepted;
        int task_runs;
        int full_adds;
        int bad_deletes;
        int saturations;
        int widest_dispatch;

        function new();
            foreach (slot_state[i]) slot_state[i] = '0;
        endfunction

        function void queue_result(cmd_e kind, slot_out_t slot, logic [7:0] job, logic ok);
            sched_result_t r;
            r.kind    = kind;
            r.slot    = slot;
            r.job     = job;
            r.ok      = ok;
            r.is_last = 1'b0;
            expected_results.push_back(r);
        endfunction

        // Apply one accepted request to the table and queue its results
        function void note_request(cmd_e cmd, logic [7:0] code, logic [31:0] first_delay,
                                   logic [31:0] period, logic [7:0] sel);
            int free_idx;
            int runs;
            free_idx = -1;
            runs = 0;
            accepted++;
            case (cmd)
                CMD_ADD: begin
                    for (int i = 0; i < TASK_SLOTS; i++)
                        if (!slot_state[i].valid && free_idx < 0) free_idx = i;
                    if (free_idx >= 0) begin
                        slot_state[free_idx].valid   = 1'b1;
                        slot_state[free_idx].job     = code;
                        slot_state[free_idx].delay   = first_delay;
                        slot_state[free_idx].period  = period;
                        slot_state[free_idx].pending = 8'd0;
                        queue_result(CMD_ADD, slot_out_t'(free_idx), 8'd0, 1'b1);
                    end else begin
                        full_adds++;
                        queue_result(CMD_ADD, SLOT_NONE, 8'd0, 1'b0);
                    end
                end
                CMD_DELETE: begin
                    if (sel < TASK_SLOTS) begin
                        queue_result(CMD_DELETE, slot_out_t'(sel), 8'd0, slot_state[sel].valid);
                        slot_state[sel] = '0;
                    end else begin
                        bad_deletes++;
                        queue_result(CMD_DELETE, SLOT_NONE, 8'd0, 1'b0);
                    end
                end
                CMD_TICK: begin
                    foreach (slot_state[i]) begin
                        if (!slot_state[i].valid) continue;
                        if (slot_state[i].delay == 0) begin
                            // run count holds at its maximum
                            if (slot_state[i].pending != 8'hFF)
                                slot_state[i].pending = slot_state[i].pending + 8'd1;
                            else
                                saturations++;
                            if (slot_state[i].period != 0)
                                slot_state[i].delay = slot_state[i].period;
                        end else begin
                            slot_state[i].delay = slot_state[i].delay - 32'd1;
                        end
                    end
                    queue_result(CMD_TICK, SLOT_NONE, 8'd0, 1'b1);
                end
                default: begin
                    // dispatch: one run per ready slot, lowest slot first
                    for (int i = 0; i < TASK_SLOTS && runs < MAX_RESULTS; i++) begin
                        if (!slot_state[i].valid || slot_state[i].pending == 0) continue;
                        queue_result(CMD_DISPATCH, slot_out_t'(i), slot_state[i].job, 1'b1);
                        runs++;
                        slot_state[i].pending = slot_state[i].pending - 8'd1;
                        if (slot_state[i].period == 0) slot_state[i] = '0;
                    end
                    if (runs == 0) queue_result(CMD_DISPATCH, SLOT_NONE, 8'd0, 1'b0);
                    task_runs += runs;
                    if (runs > widest_dispatch) widest_dispatch = runs;
                end
            endcase
            expected_results[expected_results.size() - 1].is_last = 1'b1;
        endfunction

        task report_mismatch(string what, longint got, longint want);
            errors++;
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
                     $time, what, got, want, checked);
        endtask

        // Compare one accepted result with the oldest expectation
        task check_result(logic [1:0] kind_bits, logic [15:0] data, logic last_bit);
            sched_result_t want;
            if (expected_results.size() == 0) begin
                report_mismatch("result with none expected", data, 0);
                return;
            end
            want = expected_results.pop_front();
            checked++;
            if (kind_bits !== want.kind)    report_mismatch("kind", kind_bits, want.kind);
            if (data[4:0] !== want.slot)    report_mismatch("slot", data[4:0], want.slot);
            if (data[12:5] !== want.job)    report_mismatch("job_code", data[12:5], want.job);
            if (data[13] !== want.ok)       report_mismatch("ok", data[13], want.ok);
            if (data[15:14] !== 2'b00)      report_mismatch("pad bits", data[15:14], 0);
            if (last_bit !== want.is_last)  report_mismatch("last", last_bit, want.is_last);
        endtask
    endclass

endpackage

// ===== test/tb_tick_task_scheduler_table.sv =====
// Testbench top for the tick task scheduler table: drives requests with
// random gaps, stalls the result side and checks every result.
// Depends on tts_pkg, tts_sched_sb_pkg and the tick_task_scheduler_table RTL.
module tb_tick_task_scheduler_table;
    import tts_pkg::*;
    import tts_sched_sb_pkg::*;

    localparam int IDLE_LIMIT = 4000;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata  = '0;   // [7:0] task_code, [39:8] first_delay,
                                  // [71:40] repeat_period, [79:72] slot_select
    logic [1:0]  s_tuser  = CMD_ADD;  // [1:0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;         // [4:0] slot, [12:5] job_code, [13] ok, [15:14] zero
    logic [1:0]  m_tuser;         // [1:0] kind
    logic        m_tlast;

    sched_scoreboard sb;
    bit idle_on = 1'b1;
    int rx_stall = 0;

    tick_task_scheduler_table dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #6 aclk = ~aclk;

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
    endfunction

    // Present one request and hold it until accepted
    task automatic send_request(cmd_e cmd, logic [7:0] code, logic [31:0] first_delay,
                                logic [31:0] period, logic [7:0] sel);
        int gap;
        gap = (idle_on && $urandom_range(0, 1) == 0) ? pick_gap() : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {sel, period, first_delay, code};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cmd, code, first_delay, period, sel);
    endtask

    // Hold off the sender until every expected result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.expected_results.size() != 0);
    endtask

    // Result side: check and apply random back-pressure
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tuser, m_tdata, m_tlast);
        if (rx_stall != 0) begin
            rx_stall = rx_stall - 1;
            m_tready <= 1'b0;
        end else if (!idle_on || $urandom_range(0, 3) != 0) begin
            m_tready <= 1'b1;
        end else begin
            rx_stall = pick_gap() - 1;
            m_tready <= 1'b0;
        end
    end

    // Watchdog on cycles without any handshake
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("** tick_task_scheduler_table: FAILED **");
        $finish;
    end

    initial begin
        int r;
        cmd_e cmd;
        logic [31:0] dly;
        logic [31:0] per;
        logic [7:0] sel;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Empty table: nothing to run, tick with no slots, deletes at and past the bound
        send_request(CMD_DISPATCH, 8'h00, 32'h0, 32'h0, 8'h00);
        send_request(CMD_TICK, 8'h00, 32'h0, 32'h0, 8'h00);
        send_request(CMD_DELETE, 8'h00, 32'h0, 32'h0, 8'd0);
        send_request(CMD_DELETE, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
        send_request(CMD_DELETE, 8'h00, 32'h0, 32'h0, 8'd16);
        send_request(CMD_DELETE, 8'h00, 32'h0, 32'h0, 8'd15);

        // One-shot with zero delay, never-due slot, period-one slot
        send_request(CMD_ADD, 8'hFF, 32'h0, 32'h0, 8'h00);
        send_request(CMD_ADD, 8'h00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'h00);
        send_request(CMD_ADD, 8'hA5, 32'd1, 32'd1, 8'h00);
        send_request(CMD_TICK, 8'h00, 32'h0, 32'h0, 8'h00);
        send_request(CMD_TICK, 8'h00, 32'h0, 32'h0, 8'h00);
        send_request(CMD_DISPATCH, 8'h00, 32'h0, 32'h0, 8'h00);
        send_request(CMD_DELETE, 8'h00, 32'h0, 32'h0, 8'd1);
        wait_drained();

        // Fill the table, overflow it, then run every newly added slot in one dispatch
        for (int i = 0; i < 16; i++)
            send_request(CMD_ADD, 8'(8'h30 + i), 32'h0, 32'd1, 8'h00);
        send_request(CMD_TICK, 8'h00, 32'h0, 32'h0, 8'h00);
        send_request(CMD_DISPATCH, 8'h00, 32'h0, 32'h0, 8'h00);

        // Clear everything back to back, then let a zero-delay one-shot pile up runs
        idle_on = 1'b0;
        for (int i = 0; i < TASK_SLOTS; i++)
            send_request(CMD_DELETE, 8'($urandom), $urandom, $urandom, 8'(i));
        send_request(CMD_ADD, 8'h5A, 32'h0, 32'h0, 8'h00);
        for (int i = 0; i < 3; i++)
            send_request(CMD_TICK, 8'($urandom), $urandom, $urandom, 8'($urandom));
        send_request(CMD_DISPATCH, 8'h00, 32'h0, 32'h0, 8'h00);
        send_request(CMD_DISPATCH, 8'h00, 32'h0, 32'h0, 8'h00);
        wait_drained();

        // Random traffic, short delays and periods mostly so slots keep firing
        for (int n = 0; n < 108; n++) begin
            if (n % 40 == 0) idle_on = (n != 80);
            if ($urandom_range(0, 24) == 0) wait_drained();
            r = $urandom_range(0, 99);
            if (r < 30)      cmd = CMD_ADD;
            else if (r < 45) cmd = CMD_DELETE;
            else if (r < 75) cmd = CMD_TICK;
            else             cmd = CMD_DISPATCH;
            r = $urandom_range(0, 9);
            dly = (r < 7) ? $urandom_range(0, 3) : (r < 9) ? $urandom_range(0, 20) : $urandom;
            r = $urandom_range(0, 19);
            per = (r < 7) ? 32'd0 : (r < 16) ? $urandom_range(1, 4) :
                  (r < 18) ? $urandom_range(5, 20) : $urandom;
            sel = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 15)) : 8'($urandom);
            send_request(cmd, 8'($urandom), dly, per, sel);
        end

        wait_drained();
        repeat (40) @(posedge aclk);
        if (sb.expected_results.size() != 0)
            sb.report_mismatch("results never returned", sb.expected_results.size(), 0);

        $display("Sent %0d requests and checked %0d results, %0d of them task runs.",
                 sb.accepted, sb.checked, sb.task_runs);
        $display("Full-table adds %0d, out-of-range deletes %0d, saturated ticks %0d, %0s %0d.",
                 sb.full_adds, sb.bad_deletes, sb.saturations, "widest dispatch",
                 sb.widest_dispatch);
        if (sb.errors == 0) begin
            $display("** tick_task_scheduler_table: PASSED **");
        end else begin
            $display("** tick_task_scheduler_table: FAILED **");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/tts_pkg.sv
rtl/tts_cell.sv
rtl/tts_head.sv
rtl/tick_task_scheduler_table.sv
test/tts_sched_scoreboard.sv
test/tb_tick_task_scheduler_table.sv
